### src/vae_pkg.sv
// shared constants for the vector azimuth and elevation pipeline
package vae_pkg;

    localparam int GUARD_BITS = 16;
    localparam int ACC_W = 32;
    localparam int THRESHOLD_W = 16;
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    localparam logic [31:0] ATAN_TABLE [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10680094, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81,
        32'd41, 32'd20, 32'd10, 32'd5,
        32'd3, 32'd1, 32'd1, 32'd0
    };

endpackage

### src/vae_cordic_stage.sv
// one registered cordic vectoring iteration with sideband data
module vae_cordic_stage #(
    parameter int DW = 35,
    parameter int SHIFT = 0,
    parameter int SIDE_W = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [DW-1:0]         in_a,
    input  logic signed [DW-1:0]         in_b,
    input  logic [vae_pkg::ACC_W-1:0]    in_ang,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic signed [DW-1:0]         out_a,
    output logic signed [DW-1:0]         out_b,
    output logic [vae_pkg::ACC_W-1:0]    out_ang,
    output logic [SIDE_W-1:0]            out_side
);

    localparam logic [vae_pkg::ACC_W-1:0] ATAN_STEP = vae_pkg::ATAN_TABLE[SHIFT];

    logic                      valid_reg;
    logic signed [DW-1:0]      a_reg, a_next;
    logic signed [DW-1:0]      b_reg, b_next;
    logic [vae_pkg::ACC_W-1:0] ang_reg, ang_next;
    logic [SIDE_W-1:0]         side_reg;

    always_comb begin
        if (!in_b[DW-1]) begin
            a_next   = in_a + (in_b >>> SHIFT);
            b_next   = in_b - (in_a >>> SHIFT);
            ang_next = in_ang + ATAN_STEP;
        end else begin
            a_next   = in_a - (in_b >>> SHIFT);
            b_next   = in_b + (in_a >>> SHIFT);
            ang_next = in_ang - ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            ang_reg  <= ang_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_ang   = ang_reg;
    assign out_side  = side_reg;

endmodule

### src/vae_gain_stage.sv
// gain correction of the horizontal magnitude and vertical test, two stages
module vae_gain_stage #(
    parameter int DW = 35,
    parameter int CW = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic [vae_pkg::THRESHOLD_W-1:0]   threshold,
    input  logic                              in_valid,
    input  logic signed [DW-1:0]              in_mag,
    input  logic signed [CW-1:0]              in_z,
    input  logic [vae_pkg::ACC_W-1:0]         in_az,
    output logic                              out_valid,
    output logic signed [DW-1:0]              out_ex,
    output logic signed [DW-1:0]              out_ez,
    output logic [vae_pkg::ACC_W-1:0]         out_az,
    output logic                              out_vertical,
    output logic                              out_zpos
);

    localparam int HW = (DW > 32) ? DW - 32 : 1;
    localparam int SW = HW + 33;

    logic [DW-1:0]             mag_u;
    logic [HW+31:0]            mag_ext;
    logic [HW+31:0]            p_hi_next;
    logic [63:0]               p_lo_next;
    logic [SW-1:0]             rt_full;
    logic [SW-1:0]             thr_cmp;

    logic                      v1_reg;
    logic [HW+31:0]            p_hi_reg;
    logic [63:0]               p_lo_reg;
    logic signed [CW-1:0]      z1_reg;
    logic [vae_pkg::ACC_W-1:0] az1_reg;

    logic                      v2_reg;
    logic signed [DW-1:0]      ex_reg;
    logic signed [DW-1:0]      ez_reg;
    logic [vae_pkg::ACC_W-1:0] az2_reg;
    logic                      vert_reg;
    logic                      zpos_reg;

    always_comb begin
        mag_u     = in_mag[DW-1] ? '0 : in_mag;
        mag_ext   = (HW+32)'(mag_u);
        p_lo_next = mag_ext[31:0] * vae_pkg::INV_GAIN_Q32;
        p_hi_next = mag_ext[HW+31:32] * vae_pkg::INV_GAIN_Q32;
        rt_full   = SW'(p_hi_reg) + SW'(p_lo_reg[63:32]);
        thr_cmp   = SW'({threshold, {vae_pkg::GUARD_BITS{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_hi_reg <= p_hi_next;
            p_lo_reg <= p_lo_next;
            z1_reg   <= in_z;
            az1_reg  <= in_az;
            ex_reg   <= $signed(rt_full[DW-1:0]);
            ez_reg   <= {{(DW-CW-vae_pkg::GUARD_BITS){z1_reg[CW-1]}}, z1_reg,
                         {vae_pkg::GUARD_BITS{1'b0}}};
            az2_reg  <= az1_reg;
            vert_reg <= (rt_full <= thr_cmp);
            zpos_reg <= (z1_reg > 0);
        end
    end

    assign out_valid    = v2_reg;
    assign out_ex       = ex_reg;
    assign out_ez       = ez_reg;
    assign out_az       = az2_reg;
    assign out_vertical = vert_reg;
    assign out_zpos     = zpos_reg;

endmodule

### src/vae_out_skid.sv
// output register with skid slot so the pipeline keeps taking requests
module vae_out_skid #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         in_ready,
    output logic         out_valid,
    output logic [W-1:0] out_data,
    input  logic         out_ready
);

    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] skid_data_reg, skid_data_next;
    logic         take;

    always_comb begin
        take            = in_valid && !skid_valid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            out_valid_next  = skid_valid_reg || take;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### src/vector_azimuth_elevation.sv
// top level: pipelined cordic azimuth and negated elevation of a 3-d vector
// usage:
//   s_tdata carries one vector request (x, y, z); m_tdata returns azimuth and
//   negated elevation as binary angles, full scale plus or minus pi
//   horizontal_threshold sits at apb address 0 and must be written while
//   idle; the block itself does not enforce this
// pipeline: one pre-rotation stage, one stage per azimuth iteration, two
//   gain-multiply stages, one stage per elevation iteration, and the output
//   register
// throughput: one vector per cycle unless stalled, set by the unrolled stages
// reset: aresetn low clears all valid bits and sets the threshold to 0
// stall: when m_tready is low the result holds, a skid slot takes one more
//   result, then s_tready drops and the whole pipeline freezes in place
module vector_azimuth_elevation #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // x, y, z from the lowest bit up
    input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // azimuth, neg_elevation from the lowest bit up
    output logic [((2*ANGLE_WIDTH+7)/8)*8-1:0]          m_tdata,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [2:0]                                  paddr,
    input  logic [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int N = CORDIC_STAGES;
    localparam int GB = vae_pkg::GUARD_BITS;
    localparam int DW = CW + GB + 3;
    localparam int AZW = vae_pkg::ACC_W;
    localparam int ELS = AZW + 2;
    localparam int MW = ((2*AW+7)/8)*8;
    localparam logic [AZW-1:0] HALF = AZW'((64'd1 << (32 - AW)) >> 1);
    localparam logic [AW-1:0] QUARTER = AW'(1) << (AW - 2);

    function automatic logic [AW-1:0] round_angle(input logic [AZW-1:0] acc);
        logic [AZW-1:0] sum;
        sum = acc + HALF;
        return sum[AZW-1 -: AW];
    endfunction

    logic                                 en;
    logic [vae_pkg::THRESHOLD_W-1:0]      thr_reg;

    logic signed [CW-1:0]                 in_x, in_y, in_z;
    logic signed [DW-1:0]                 x_s, y_s;

    logic                                 az_v   [0:N];
    logic signed [DW-1:0]                 az_a   [0:N];
    logic signed [DW-1:0]                 az_b   [0:N];
    logic [AZW-1:0]                       az_ang [0:N];
    logic [CW-1:0]                        az_side[0:N];

    logic                                 el_v   [0:N];
    logic signed [DW-1:0]                 el_a   [0:N];
    logic signed [DW-1:0]                 el_b   [0:N];
    logic [AZW-1:0]                       el_ang [0:N];
    logic [ELS-1:0]                       el_side[0:N];

    logic [AZW-1:0]                       g_az;
    logic                                 g_vert, g_zpos;

    logic [AW-1:0]                        res_az, res_nel;
    logic [MW-1:0]                        res_data;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == vae_pkg::REG_THRESHOLD) begin
            thr_reg <= pwdata[vae_pkg::THRESHOLD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == vae_pkg::REG_THRESHOLD) ? 32'(thr_reg) : '0;

    // pre-rotation stage
    assign in_x = s_tdata[CW-1:0];
    assign in_y = s_tdata[2*CW-1:CW];
    assign in_z = s_tdata[3*CW-1:2*CW];
    assign x_s  = {{(DW-CW-GB){in_x[CW-1]}}, in_x, {GB{1'b0}}};
    assign y_s  = {{(DW-CW-GB){in_y[CW-1]}}, in_y, {GB{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            az_v[0] <= 1'b0;
        end else if (en) begin
            az_v[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            az_a[0]    <= in_x[CW-1] ? -x_s : x_s;
            az_b[0]    <= in_x[CW-1] ? -y_s : y_s;
            az_ang[0]  <= in_x[CW-1] ? {1'b1, {(AZW-1){1'b0}}} : '0;
            az_side[0] <= in_z;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_az_stage
            vae_cordic_stage #(.DW(DW), .SHIFT(i), .SIDE_W(CW)) u_stage (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .in_valid(az_v[i]), .in_a(az_a[i]), .in_b(az_b[i]),
                .in_ang(az_ang[i]), .in_side(az_side[i]),
                .out_valid(az_v[i+1]), .out_a(az_a[i+1]), .out_b(az_b[i+1]),
                .out_ang(az_ang[i+1]), .out_side(az_side[i+1])
            );
        end
    endgenerate

    vae_gain_stage #(.DW(DW), .CW(CW)) u_gain (
        .aclk(aclk), .aresetn(aresetn), .en(en), .threshold(thr_reg),
        .in_valid(az_v[N]), .in_mag(az_a[N]), .in_z(az_side[N]), .in_az(az_ang[N]),
        .out_valid(el_v[0]), .out_ex(el_a[0]), .out_ez(el_b[0]), .out_az(g_az),
        .out_vertical(g_vert), .out_zpos(g_zpos)
    );

    assign el_ang[0]  = '0;
    assign el_side[0] = {g_az, g_vert, g_zpos};

    generate
        for (i = 0; i < N; i++) begin : g_el_stage
            vae_cordic_stage #(.DW(DW), .SHIFT(i), .SIDE_W(ELS)) u_stage (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .in_valid(el_v[i]), .in_a(el_a[i]), .in_b(el_b[i]),
                .in_ang(el_ang[i]), .in_side(el_side[i]),
                .out_valid(el_v[i+1]), .out_a(el_a[i+1]), .out_b(el_b[i+1]),
                .out_ang(el_ang[i+1]), .out_side(el_side[i+1])
            );
        end
    endgenerate

    // final rounding and vertical override
    always_comb begin
        if (el_side[N][1]) begin
            res_az  = '0;
            res_nel = el_side[N][0] ? -QUARTER : QUARTER;
        end else begin
            res_az  = round_angle(el_side[N][ELS-1:2]);
            res_nel = round_angle(-el_ang[N]);
        end
        res_data = MW'({res_nel, res_az});
    end

    vae_out_skid #(.W(MW)) u_out (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(el_v[N]), .in_data(res_data), .in_ready(en),
        .out_valid(m_tvalid), .out_data(m_tdata), .out_ready(m_tready)
    );

    assign s_tready = en;

    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled without a pending result");

    a_last_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (el_v[N] && !en) |=> el_v[N])
        else $error("result dropped from last stage during stall");

    a_entry_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> az_v[0])
        else $error("accepted request not captured in entry stage");

    a_frozen_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (az_v[0] == $past(az_v[0])))
        else $error("entry stage moved while pipeline frozen");

endmodule

### verif/tb_vector_azimuth_elevation.sv
// testbench for vector_azimuth_elevation: random and directed vectors against a cordic predictor
`timescale 1ns / 1ps

module tb_vector_azimuth_elevation;

    localparam int COMPONENT_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY = 2 * CORDIC_STAGES + 4;
    localparam int SETTLE_CYCLES = LATENCY + 10;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int FULL_SPAN = 32768;
    localparam longint ONE = 64'sd1 <<< vae_pkg::GUARD_BITS;
    localparam logic [2:0] THRESHOLD_ADDR = {vae_pkg::REG_THRESHOLD, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;
    localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_TURN = 1 <<< (ANGLE_WIDTH - 2);

    typedef logic signed [COMPONENT_WIDTH-1:0] component_t;
    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

    typedef struct packed {
        angle_t azimuth;
        angle_t neg_elevation;
    } angle_pair_t;

    class angle_scoreboard;
        logic [vae_pkg::THRESHOLD_W-1:0] threshold;
        angle_pair_t expected_angles[$];
        int errors;
        int results_checked;

        function new();
            threshold = '0;
            errors = 0;
            results_checked = 0;
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction

        // vectors (a, b) onto the positive x axis, returns swept angle and final a
        function bit [vae_pkg::ACC_W-1:0] cordic_vector(input longint a, input longint b,
                                                        output longint mag);
            bit [vae_pkg::ACC_W-1:0] ang;
            longint na, nb;
            ang = '0;
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
                if (b >= 0) begin
                    na = a + (b >>> i);
                    nb = b - (a >>> i);
                    ang += vae_pkg::ATAN_TABLE[i];
                end else begin
                    na = a - (b >>> i);
                    nb = b + (a >>> i);
                    ang -= vae_pkg::ATAN_TABLE[i];
                end
                a = na;
                b = nb;
            end
            mag = a;
            return ang;
        endfunction

        function angle_t round_angle(input bit [vae_pkg::ACC_W-1:0] acc);
            bit [vae_pkg::ACC_W-1:0] r;
            r = acc + (32'd1 << (vae_pkg::ACC_W - 1 - ANGLE_WIDTH));
            return r[vae_pkg::ACC_W-1 -: ANGLE_WIDTH];
        endfunction

        function angle_pair_t predict_angles(input component_t x, input component_t y,
                                             input component_t z);
            angle_pair_t res;
            longint hx, hy, ex, ez, mag;
            longint unsigned r, rt;
            bit [vae_pkg::ACC_W-1:0] az_acc, el_acc;
            hx = longint'(x) * ONE;
            hy = longint'(y) * ONE;
            az_acc = '0;
            if (hx < 0) begin
                hx = -hx;
                hy = -hy;
                az_acc = 32'h8000_0000;
            end
            az_acc += cordic_vector(hx, hy, mag);
            r = (mag < 0) ? 64'd0 : mag;
            rt = (r >> 32) * vae_pkg::INV_GAIN_Q32
                 + (((r & 64'hFFFF_FFFF) * vae_pkg::INV_GAIN_Q32) >> 32);
            if (rt <= (64'(threshold) << vae_pkg::GUARD_BITS)) begin
                res.azimuth = '0;
                res.neg_elevation = (z > 0) ? -QUARTER_TURN : QUARTER_TURN;
                return res;
            end
            ex = longint'(rt);
            ez = longint'(z) * ONE;
            el_acc = cordic_vector(ex, ez, mag);
            res.azimuth = round_angle(az_acc);
            res.neg_elevation = round_angle(32'd0 - el_acc);
            return res;
        endfunction

        function void note_vector(input component_t x, input component_t y,
                                  input component_t z);
            expected_angles.push_back(predict_angles(x, y, z));
        endfunction

        function void check_angles(input angle_t azimuth, input angle_t neg_elevation);
            angle_pair_t want;
            results_checked++;
            if (expected_angles.size() == 0) begin
                errors++;
                $display("%0t: expected no result, got azimuth %0d neg_elevation %0d",
                         $time, azimuth, neg_elevation);
                return;
            end
            want = expected_angles.pop_front();
            if (azimuth !== want.azimuth) begin
                errors++;
                $display("%0t: azimuth expected %0d, got %0d",
                         $time, want.azimuth, azimuth);
            end
            if (neg_elevation !== want.neg_elevation) begin
                errors++;
                $display("%0t: neg_elevation expected %0d, got %0d",
                         $time, want.neg_elevation, neg_elevation);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [((2*ANGLE_WIDTH+7)/8)*8-1:0] m_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    bit tx_idling = 1'b1;
    bit rx_idling = 1'b1;
    int idle_cycles = 0;
    angle_scoreboard sb = new();

    vector_azimuth_elevation #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH),
        .ANGLE_WIDTH(ANGLE_WIDTH),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result check and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_angles(m_tdata[ANGLE_WIDTH-1:0],
                                m_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side backpressure, with one long hold-off to fill the pipeline
    initial begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!long_hold_done && sb.results_checked >= 200) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            end else if (rx_idling && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
        end
    end

    function automatic component_t random_component(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 16'sh8000;
        if (pick == 1)
            return 16'sh7FFF;
        if (pick == 2)
            return '0;
        if (span >= FULL_SPAN)
            return component_t'($urandom);
        return component_t'($urandom_range(0, 2 * span)) - component_t'(span);
    endfunction

    task automatic send_vector(input component_t x, input component_t y, input component_t z);
        s_tdata <= {z, y, x};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_vector(x, y, z);
        @(negedge aclk);
    endtask

    task automatic run_vectors(input int count, input int unsigned span);
        component_t vx, vy, vz;
        int unsigned use_span;
        for (int n = 0; n < count; n++) begin
            if (tx_idling && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            use_span = ($urandom_range(0, 3) == 0) ? FULL_SPAN : span;
            vx = random_component(use_span);
            vy = random_component(use_span);
            vz = random_component($urandom_range(0, 1) ? use_span : FULL_SPAN);
            send_vector(vx, vy, vz);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (addr == THRESHOLD_ADDR)
            sb.threshold = value[vae_pkg::THRESHOLD_W-1:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // zero vector, axes, extremes and the pi wrap of the azimuth
        send_vector(0, 0, 0);
        send_vector(0, 0, 1);
        send_vector(0, 0, -1);
        send_vector(0, 0, 32767);
        send_vector(0, 0, -32768);
        send_vector(32767, 0, 0);
        send_vector(-32768, 0, 0);
        send_vector(0, 32767, 0);
        send_vector(0, -32768, 0);
        send_vector(-32768, -32768, -32768);
        send_vector(32767, 32767, 32767);
        send_vector(-32768, 32767, 0);
        send_vector(32767, -32768, -32768);
        send_vector(-1, 0, 0);
        send_vector(1, 0, 0);
        send_vector(-1, -1, 32767);
        send_vector(1, -1, -32768);
        send_vector(-32768, 0, 32767);
        send_vector(0, 1, -1);
        send_vector(-32767, 1, 5);

        // unmapped address must leave the threshold alone
        drain_results();
        apb_write(UNMAPPED_ADDR, 32'h0000_FFFF);
        run_vectors(300, FULL_SPAN);

        drain_results();
        apb_write(THRESHOLD_ADDR, 32'h0000_FFFF);
        run_vectors(100, FULL_SPAN);

        drain_results();
        apb_write(THRESHOLD_ADDR, $urandom_range(1, 3000));
        run_vectors(300, 4000);

        drain_results();
        apb_write(THRESHOLD_ADDR, $urandom_range(0, 65535));
        run_vectors(200, FULL_SPAN);

        drain_results();
        apb_write(THRESHOLD_ADDR, $urandom_range(0, 63));
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_vectors(330, 256);

        drain_results();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
